@@ sv/aphm_pkg.sv @@
// ============================================================================
// aphm_pkg: shared types, constants and arithmetic helpers
// Widths, command codes and the fixed-point helpers used by the peak meter.
// ============================================================================
package aphm_pkg;

    localparam int BIN_COUNT         = 192;
    localparam int PTR_W             = $clog2(BIN_COUNT);
    localparam int Q_W               = 15;
    localparam int SAMPLE_W          = 16;
    localparam int FRAMES_W          = 13;
    localparam int MAX_BLOCK_FRAMES  = 4096;
    localparam int MAX_SLICES        = 16;
    localparam int SLICE_W           = 5;
    localparam int SLICE_SHIFT       = 6;
    localparam int READ_INDEX_W      = 8;
    localparam int CMD_W             = 2;
    localparam int CFG_INDEX_W       = 1;
    localparam int SUM_W             = (PTR_W > READ_INDEX_W ? PTR_W : READ_INDEX_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEVEL_DECAY = 1'b0,
        CFG_BIN_DECAY   = 1'b1
    } t_cfg_index;

    localparam logic [Q_W-1:0] LEVEL_DECAY_RESET = Q_W'(29491);
    localparam logic [Q_W-1:0] BIN_DECAY_RESET   = Q_W'(30802);

    // Q0.15 scaling, truncated toward zero.
    function automatic logic [Q_W-1:0] decay(input logic [Q_W-1:0] value,
                                             input logic [Q_W-1:0] factor);
        logic [2*Q_W-1:0] prod;
        prod = value * factor;
        return prod[2*Q_W-1:Q_W];
    endfunction

    // Magnitude of a Q1.15 sample; full scale negative saturates.
    function automatic logic [Q_W-1:0] magnitude(input logic [SAMPLE_W-1:0] sample);
        logic [SAMPLE_W-1:0] neg;
        neg = -sample;
        if (!sample[SAMPLE_W-1]) begin
            return sample[Q_W-1:0];
        end
        if (neg[SAMPLE_W-1]) begin
            return {Q_W{1'b1}};
        end
        return neg[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] max_q(input logic [Q_W-1:0] a,
                                             input logic [Q_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ sv/aphm_ram.sv @@
// ============================================================================
// aphm_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ============================================================================
module aphm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/aphm_div.sv @@
// ============================================================================
// aphm_div: iterative frame-count divider
// Restoring division of the block length by the slice count, one bit a cycle.
// ============================================================================
module aphm_div
    import aphm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [FRAMES_W-1:0] i_dividend,
    input  logic [SLICE_W-1:0]  i_divisor,
    output logic                o_done,
    output logic [FRAMES_W-1:0] o_quotient
);

    localparam int COUNT_W = $clog2(FRAMES_W);

    logic               r_busy;
    logic               r_done;
    logic [COUNT_W-1:0] r_count;
    logic [FRAMES_W-1:0] r_work;
    logic [SLICE_W-1:0] r_rem;
    logic [SLICE_W-1:0] r_divisor;

    logic [SLICE_W:0]   trial;
    logic               fits;
    logic [SLICE_W:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_work[FRAMES_W-1]};
        fits  = trial >= {1'b0, r_divisor};
        n_rem = fits ? (trial - {1'b0, r_divisor}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_count   <= '0;
            r_work    <= '0;
            r_rem     <= '0;
            r_divisor <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_count   <= COUNT_W'(FRAMES_W - 1);
                r_work    <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                // The remainder stays below the divisor, so it fits the narrow register.
                r_rem  <= n_rem[SLICE_W-1:0];
                r_work <= {r_work[FRAMES_W-2:0], fits};
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

@@ sv/audio_peak_history_meter.sv @@
// ============================================================================
// audio_peak_history_meter: stereo peak meter with a peak history ring
// Slices render blocks of stereo frames, keeps a ring of slice peaks in a
// memory, and keeps two decaying channel levels.
// ============================================================================
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  ------------------------
//  request   i_command, i_*_sample, i_block_frames,    taken when start is high
//            i_read_index                              and busy is low
//  result    o_bin_value, o_level_left_out,            o_result_valid, one cycle
//            o_level_right_out                         only; cannot be held off
//  config    i_cfg_we, i_cfg_index, i_cfg_data         written when i_cfg_we high
//
// A clear request never raises busy. A frame request passes through S_FRAME,
// waiting first in S_DIV on the first frame of a block, where the iterative
// divider finds the slice size one bit of the block length per cycle. A read
// request passes three steps (address, memory read, result register) and its
// result appears in the same cycle that busy falls. A tick request decays both
// levels, then sweeps the history memory through its single read port, reading
// each bin in S_TICK_RD and writing it back in S_TICK_WR. Reset is synchronous
// and needs no clearing pass: one valid flop per bin makes a bin read as zero
// until it is written, and a clear request drops all of them at once.
// ============================================================================
module audio_peak_history_meter
    import aphm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic [FRAMES_W-1:0]        i_block_frames,
    input  logic [READ_INDEX_W-1:0]    i_read_index,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [Q_W-1:0]             i_cfg_data,
    output logic                       o_result_valid,
    output logic [Q_W-1:0]             o_bin_value,
    output logic [Q_W-1:0]             o_level_left_out,
    output logic [Q_W-1:0]             o_level_right_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FRAME,
        S_TICK_RD,
        S_TICK_WR,
        S_READ,
        S_READ_WAIT
    } t_state;

    t_state r_state;

    // Configuration.
    logic [Q_W-1:0] r_level_decay;
    logic [Q_W-1:0] r_bin_decay;

    // History ring bookkeeping; the bins themselves live in the memory.
    logic [BIN_COUNT-1:0] r_bin_valid;
    logic [PTR_W-1:0]     r_wp;
    logic [PTR_W-1:0]     r_addr;

    // Levels and slice state.
    logic [Q_W-1:0]      r_left_level;
    logic [Q_W-1:0]      r_right_level;
    logic [Q_W-1:0]      r_slice_peak;
    logic [Q_W-1:0]      r_slice_peak_left;
    logic [Q_W-1:0]      r_slice_peak_right;
    logic [FRAMES_W-1:0] r_frame_in_block;
    logic [SLICE_W-1:0]  r_slice_number;
    logic [FRAMES_W-1:0] r_frame_in_slice;
    logic [FRAMES_W-1:0] r_slice_length;
    logic [SLICE_W-1:0]  r_slice_total;

    // Latched frame request.
    logic [Q_W-1:0]      r_left_mag;
    logic [Q_W-1:0]      r_right_mag;
    logic [FRAMES_W-1:0] r_frames;

    // Result registers.
    logic           r_result_valid;
    logic [Q_W-1:0] r_bin_value;
    logic [Q_W-1:0] r_level_left_out;
    logic [Q_W-1:0] r_level_right_out;

    t_command cmd;
    logic     accept;

    logic [FRAMES_W-1:0]             in_frames;
    logic [FRAMES_W-SLICE_SHIFT-1:0] frames_div64;
    logic [SLICE_W-1:0]              in_slices;
    logic                            first_frame;

    logic [SUM_W-1:0] idx_ext;
    logic [SUM_W-1:0] idx_red;
    logic [SUM_W-1:0] addr_sum;
    logic [PTR_W-1:0] n_read_addr;

    logic [Q_W-1:0] n_peak;
    logic [Q_W-1:0] n_peak_left;
    logic [Q_W-1:0] n_peak_right;
    logic [Q_W-1:0] left_decayed;
    logic [Q_W-1:0] right_decayed;
    logic           block_end;
    logic           slice_close;

    logic           ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [Q_W-1:0] ram_wdata;
    logic [Q_W-1:0] ram_rdata;
    logic [Q_W-1:0] bin_read;

    logic                div_start;
    logic                div_done;
    logic [FRAMES_W-1:0] div_quotient;

    always_comb begin
        cmd    = t_command'(i_command);
        accept = start && (r_state == S_IDLE);

        // Block length: zero acts as one, oversized blocks saturate.
        if (i_block_frames == '0) begin
            in_frames = FRAMES_W'(1);
        end else if (i_block_frames > FRAMES_W'(MAX_BLOCK_FRAMES)) begin
            in_frames = FRAMES_W'(MAX_BLOCK_FRAMES);
        end else begin
            in_frames = i_block_frames;
        end
        frames_div64 = in_frames[FRAMES_W-1:SLICE_SHIFT];
        if (frames_div64 == '0) begin
            in_slices = SLICE_W'(1);
        end else if (frames_div64 > (FRAMES_W-SLICE_SHIFT)'(MAX_SLICES)) begin
            in_slices = SLICE_W'(MAX_SLICES);
        end else begin
            in_slices = frames_div64[SLICE_W-1:0];
        end
        first_frame = (r_frame_in_block == '0);

        // Offset from the oldest bin, wrapped around the ring.
        idx_ext  = SUM_W'(i_read_index);
        idx_red  = (idx_ext >= SUM_W'(BIN_COUNT)) ? (idx_ext - SUM_W'(BIN_COUNT)) : idx_ext;
        addr_sum = SUM_W'(r_wp) + idx_red;
        if (addr_sum >= SUM_W'(BIN_COUNT)) begin
            n_read_addr = PTR_W'(addr_sum - SUM_W'(BIN_COUNT));
        end else begin
            n_read_addr = PTR_W'(addr_sum);
        end

        // Slice peak update and slice-close decision for the latched frame.
        n_peak        = max_q(r_slice_peak, max_q(r_left_mag, r_right_mag));
        n_peak_left   = max_q(r_slice_peak_left, r_left_mag);
        n_peak_right  = max_q(r_slice_peak_right, r_right_mag);
        left_decayed  = decay(r_left_level, r_level_decay);
        right_decayed = decay(r_right_level, r_level_decay);
        block_end     = ({1'b0, r_frame_in_block} + 1'b1) >= {1'b0, r_frames};
        slice_close   = block_end ||
                        ((({1'b0, r_slice_number} + 1'b1) < {1'b0, r_slice_total}) &&
                         (({1'b0, r_frame_in_slice} + 1'b1) >= {1'b0, r_slice_length}));

        // A bin never written since reset or clear reads as zero.
        bin_read = r_bin_valid[r_addr] ? ram_rdata : '0;

        ram_we    = ((r_state == S_FRAME) && slice_close) || (r_state == S_TICK_WR);
        ram_waddr = (r_state == S_TICK_WR) ? r_addr : r_wp;
        ram_wdata = (r_state == S_TICK_WR) ? decay(bin_read, r_bin_decay) : n_peak;

        div_start = accept && (cmd == CMD_FRAME) && first_frame;
    end

    aphm_ram #(
        .WIDTH (Q_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    aphm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_frames),
        .i_divisor  (in_slices),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_level_decay      <= LEVEL_DECAY_RESET;
            r_bin_decay        <= BIN_DECAY_RESET;
            r_bin_valid        <= '0;
            r_wp               <= '0;
            r_addr             <= '0;
            r_left_level       <= '0;
            r_right_level      <= '0;
            r_slice_peak       <= '0;
            r_slice_peak_left  <= '0;
            r_slice_peak_right <= '0;
            r_frame_in_block   <= '0;
            r_slice_number     <= '0;
            r_frame_in_slice   <= '0;
            r_slice_length     <= FRAMES_W'(1);
            r_slice_total      <= SLICE_W'(1);
            r_left_mag         <= '0;
            r_right_mag        <= '0;
            r_frames           <= FRAMES_W'(1);
            r_result_valid     <= 1'b0;
            r_bin_value        <= '0;
            r_level_left_out   <= '0;
            r_level_right_out  <= '0;
        end else begin
            r_result_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_LEVEL_DECAY: r_level_decay <= i_cfg_data;
                    CFG_BIN_DECAY:   r_bin_decay   <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (cmd)
                            CMD_FRAME: begin
                                r_left_mag  <= magnitude(i_left_sample);
                                r_right_mag <= magnitude(i_right_sample);
                                r_frames    <= in_frames;
                                if (first_frame) begin
                                    r_slice_total      <= in_slices;
                                    r_slice_number     <= '0;
                                    r_frame_in_slice   <= '0;
                                    r_slice_peak       <= '0;
                                    r_slice_peak_left  <= '0;
                                    r_slice_peak_right <= '0;
                                    r_state            <= S_DIV;
                                end else begin
                                    r_state <= S_FRAME;
                                end
                            end
                            CMD_TICK: begin
                                r_left_level  <= left_decayed;
                                r_right_level <= right_decayed;
                                r_addr        <= '0;
                                r_state       <= S_TICK_RD;
                            end
                            CMD_READ: begin
                                r_addr  <= n_read_addr;
                                r_state <= S_READ;
                            end
                            CMD_CLEAR: begin
                                r_bin_valid   <= '0;
                                r_wp          <= '0;
                                r_left_level  <= '0;
                                r_right_level <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_slice_length <= (div_quotient == '0) ? FRAMES_W'(1) : div_quotient;
                        r_state        <= S_FRAME;
                    end
                end
                S_FRAME: begin
                    if (slice_close) begin
                        // The memory write of the slice peak happens on this edge.
                        r_bin_valid[r_wp]  <= 1'b1;
                        r_wp               <= (r_wp == PTR_W'(BIN_COUNT - 1)) ? '0 : r_wp + 1'b1;
                        r_left_level       <= max_q(left_decayed, n_peak_left);
                        r_right_level      <= max_q(right_decayed, n_peak_right);
                        r_slice_peak       <= '0;
                        r_slice_peak_left  <= '0;
                        r_slice_peak_right <= '0;
                        r_frame_in_slice   <= '0;
                        r_slice_number     <= block_end ? '0 : r_slice_number + 1'b1;
                    end else begin
                        r_slice_peak       <= n_peak;
                        r_slice_peak_left  <= n_peak_left;
                        r_slice_peak_right <= n_peak_right;
                        r_frame_in_slice   <= r_frame_in_slice + 1'b1;
                    end
                    r_frame_in_block <= block_end ? '0 : r_frame_in_block + 1'b1;
                    r_state          <= S_IDLE;
                end
                S_TICK_RD: begin
                    r_state <= S_TICK_WR;
                end
                S_TICK_WR: begin
                    r_bin_valid[r_addr] <= 1'b1;
                    if (r_addr == PTR_W'(BIN_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_TICK_RD;
                    end
                end
                S_READ: begin
                    r_state <= S_READ_WAIT;
                end
                S_READ_WAIT: begin
                    r_bin_value       <= bin_read;
                    r_level_left_out  <= r_left_level;
                    r_level_right_out <= r_right_level;
                    r_result_valid    <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_result_valid    = r_result_valid;
    assign o_bin_value       = r_bin_value;
    assign o_level_left_out  = r_level_left_out;
    assign o_level_right_out = r_level_right_out;

endmodule
